>>> rtl/core/interval_merge_and_lookup_top_macros.svh
// Assertion macros for the interval merge and lookup block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef INTERVAL_MERGE_AND_LOOKUP_TOP_MACROS_SVH
`define INTERVAL_MERGE_AND_LOOKUP_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IMAL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IMAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/imal_pkg.sv
// Types and constants for the interval merge and lookup block.
// No dependencies.
`default_nettype none

package imal_pkg;

    localparam int MERGED_DEPTH = 16;
    localparam int MIDX_W       = 4;
    localparam int MCNT_W       = 5;
    localparam int RANGE_W      = 16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    localparam logic KIND_LIST   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_MRG_INIT,
        S_MRG_RD,
        S_MRG_CMP,
        S_MRG_FLUSH,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_LK_RD,
        S_LK_CMP,
        S_LK_MISS
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/imal_req_if.sv
// Input channel of the interval merge and lookup block: valid/ready plus command beat.
// No dependencies.
`default_nettype none

interface imal_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] range_low;
    logic [7:0] range_high;
    logic       last_range;
    logic [7:0] query_index;

    modport source (
        output valid, command, range_low, range_high, last_range, query_index,
        input  ready
    );
    modport sink (
        input  valid, command, range_low, range_high, last_range, query_index,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/imal_rsp_if.sv
// Result channel of the interval merge and lookup block: valid/ready plus result beat.
// No dependencies.
`default_nettype none

interface imal_rsp_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_low;
    logic [7:0] out_high;
    logic [3:0] slot;
    logic       found;
    logic       overflow;
    logic       last;

    modport source (
        output valid, kind, out_low, out_high, slot, found, overflow, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_low, out_high, slot, found, overflow, last,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/imal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/interval_merge_and_lookup_top.sv
// Interval merge and lookup block: one read walk at a time over two range stores,
// under a small sequencer. Depends on imal_pkg, imal_req_if, imal_rsp_if, imal_ram
// and interval_merge_and_lookup_top_macros.svh.
//
// Ranges are kept sorted as they arrive. An add without the last mark is written
// directly when the store is empty and dropped when it is full; else each stored
// range above it is read and shifted up one slot before it is put in place.
// An add with the last mark then walks the pending store, merging overlapping
// ranges, and lists the merged ranges one beat each, stalling while a result is
// held.
// A lookup scans the merged ranges until one holds the index, else reports a miss.
// Clear empties both stores. The pace is set by the single read port of each store,
// read one entry per step. The block takes no beat while it works; the last result
// waits in an output register, so the next beat is accepted while it is held.
`default_nettype none
`include "interval_merge_and_lookup_top_macros.svh"

module interval_merge_and_lookup_top
    import imal_pkg::*;
#(
    parameter int MAX_RANGES = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    imal_req_if.sink    req,
    imal_rsp_if.source  rsp
);

    localparam int PIDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int PCNT_W = $clog2(MAX_RANGES + 1);

    state_t state_reg, state_next;

    logic [RANGE_W-1:0] key_reg, key_next;
    logic               last_reg, last_next;
    logic [7:0]         q_reg, q_next;
    logic [PCNT_W-1:0]  pcount_reg, pcount_next;
    logic [MCNT_W-1:0]  mcount_reg, mcount_next;
    logic               ovf_seen_reg, ovf_seen_next;
    logic               run_ovf_reg, run_ovf_next;
    logic [PIDX_W-1:0]  j_reg, j_next;
    logic [PCNT_W-1:0]  i_reg, i_next;
    logic [MCNT_W-1:0]  e_reg, e_next;
    logic [7:0]         cur_lo_reg, cur_lo_next;
    logic [7:0]         cur_hi_reg, cur_hi_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic               rsp_kind_reg, rsp_kind_next;
    logic [7:0]         rsp_low_reg, rsp_low_next;
    logic [7:0]         rsp_high_reg, rsp_high_next;
    logic [MIDX_W-1:0]  rsp_slot_reg, rsp_slot_next;
    logic               rsp_found_reg, rsp_found_next;
    logic               rsp_ovf_reg, rsp_ovf_next;
    logic               rsp_last_reg, rsp_last_next;

    logic               p_wr_en, p_rd_en;
    logic [PIDX_W-1:0]  p_wr_addr, p_rd_addr;
    logic [RANGE_W-1:0] p_wr_data, p_rd_data;
    logic               m_wr_en, m_rd_en;
    logic [MIDX_W-1:0]  m_wr_addr, m_rd_addr;
    logic [RANGE_W-1:0] m_wr_data, m_rd_data;

    logic               acc;
    logic               out_free;
    logic               room;
    logic               ins_shift;
    logic               lk_hit;
    logic               merge_first;
    logic               overlap;
    logic               i_at_end;
    logic               e_at_end;
    logic [PCNT_W-1:0]  i_inc;
    logic [MCNT_W-1:0]  e_inc;
    logic [7:0]         p_lo, p_hi, m_lo, m_hi;

    assign acc       = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign room      = (pcount_reg < PCNT_W'(MAX_RANGES));

    assign p_lo = p_rd_data[15:8];
    assign p_hi = p_rd_data[7:0];
    assign m_lo = m_rd_data[15:8];
    assign m_hi = m_rd_data[7:0];

    assign i_inc    = i_reg + PCNT_W'(1);
    assign e_inc    = e_reg + MCNT_W'(1);
    assign i_at_end = (i_inc == pcount_reg);
    assign e_at_end = (e_inc == mcount_reg);

    assign ins_shift   = (p_rd_data > key_reg);
    assign merge_first = (i_reg == '0);
    assign overlap     = (cur_hi_reg >= p_lo);
    assign lk_hit      = (q_reg >= m_lo) && (q_reg <= m_hi);

    imal_ram #(
        .WIDTH (RANGE_W),
        .DEPTH (MAX_RANGES)
    ) u_pending (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (p_wr_addr),
        .wr_data (p_wr_data),
        .rd_en   (p_rd_en),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd_data)
    );

    imal_ram #(
        .WIDTH (RANGE_W),
        .DEPTH (MERGED_DEPTH)
    ) u_merged (
        .clk     (clk),
        .wr_en   (m_wr_en),
        .wr_addr (m_wr_addr),
        .wr_data (m_wr_data),
        .rd_en   (m_rd_en),
        .rd_addr (m_rd_addr),
        .rd_data (m_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (cmd_t'(req.command))
                        CMD_ADD:
                        begin
                            if (room && (pcount_reg != '0))
                            begin
                                state_next = S_INS_RD;
                            end
                            else if (req.last_range)
                            begin
                                state_next = S_MRG_INIT;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            state_next = (mcount_reg == '0) ? S_LK_MISS : S_LK_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (ins_shift)
                begin
                    state_next = (j_reg == PIDX_W'(1)) ? S_INS_PUT : S_INS_RD;
                end
                else
                begin
                    state_next = last_reg ? S_MRG_INIT : S_IDLE;
                end
            end
            S_INS_PUT:
            begin
                state_next = last_reg ? S_MRG_INIT : S_IDLE;
            end
            S_MRG_INIT:
            begin
                state_next = S_MRG_RD;
            end
            S_MRG_RD:
            begin
                state_next = S_MRG_CMP;
            end
            S_MRG_CMP:
            begin
                state_next = i_at_end ? S_MRG_FLUSH : S_MRG_RD;
            end
            S_MRG_FLUSH:
            begin
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = e_at_end ? S_IDLE : S_EMIT_RD;
                end
            end
            S_LK_RD:
            begin
                state_next = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                if (lk_hit)
                begin
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = e_at_end ? S_LK_MISS : S_LK_RD;
                end
            end
            S_LK_MISS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, store ports and result register
    always_comb
    begin
        key_next       = key_reg;
        last_next      = last_reg;
        q_next         = q_reg;
        pcount_next    = pcount_reg;
        mcount_next    = mcount_reg;
        ovf_seen_next  = ovf_seen_reg;
        run_ovf_next   = run_ovf_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        e_next         = e_reg;
        cur_lo_next    = cur_lo_reg;
        cur_hi_next    = cur_hi_reg;

        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_kind_next  = rsp_kind_reg;
        rsp_low_next   = rsp_low_reg;
        rsp_high_next  = rsp_high_reg;
        rsp_slot_next  = rsp_slot_reg;
        rsp_found_next = rsp_found_reg;
        rsp_ovf_next   = rsp_ovf_reg;
        rsp_last_next  = rsp_last_reg;

        p_wr_en   = 1'b0;
        p_wr_addr = j_reg;
        p_wr_data = key_reg;
        p_rd_en   = 1'b0;
        p_rd_addr = i_reg[PIDX_W-1:0];
        m_wr_en   = 1'b0;
        m_wr_addr = mcount_reg[MIDX_W-1:0];
        m_wr_data = {cur_lo_reg, cur_hi_reg};
        m_rd_en   = 1'b0;
        m_rd_addr = e_reg[MIDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    key_next  = {req.range_low, req.range_high};
                    last_next = req.last_range;
                    q_next    = req.query_index;
                    case (cmd_t'(req.command))
                        CMD_ADD:
                        begin
                            if (!room)
                            begin
                                ovf_seen_next = 1'b1;
                            end
                            else if (pcount_reg == '0)
                            begin
                                p_wr_en     = 1'b1;
                                p_wr_addr   = '0;
                                p_wr_data   = {req.range_low, req.range_high};
                                pcount_next = PCNT_W'(1);
                            end
                            else
                            begin
                                j_next = pcount_reg[PIDX_W-1:0];
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            e_next = '0;
                        end
                        CMD_CLEAR:
                        begin
                            pcount_next   = '0;
                            mcount_next   = '0;
                            ovf_seen_next = 1'b0;
                        end
                        default:
                        begin
                            e_next = e_reg;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                p_rd_en   = 1'b1;
                p_rd_addr = j_reg - PIDX_W'(1);
            end
            S_INS_CMP:
            begin
                p_wr_en = 1'b1;
                if (ins_shift)
                begin
                    p_wr_data = p_rd_data;
                    j_next    = j_reg - PIDX_W'(1);
                end
                else
                begin
                    pcount_next = pcount_reg + PCNT_W'(1);
                end
            end
            S_INS_PUT:
            begin
                p_wr_en     = 1'b1;
                pcount_next = pcount_reg + PCNT_W'(1);
            end
            S_MRG_INIT:
            begin
                mcount_next  = '0;
                i_next       = '0;
                run_ovf_next = ovf_seen_reg;
            end
            S_MRG_RD:
            begin
                p_rd_en = 1'b1;
            end
            S_MRG_CMP:
            begin
                i_next = i_inc;
                if (merge_first || !overlap)
                begin
                    if (!merge_first)
                    begin
                        if (mcount_reg[MCNT_W-1])
                        begin
                            run_ovf_next = 1'b1;
                        end
                        else
                        begin
                            m_wr_en     = 1'b1;
                            mcount_next = mcount_reg + MCNT_W'(1);
                        end
                    end
                    cur_lo_next = p_lo;
                    cur_hi_next = p_hi;
                end
                else if (p_hi > cur_hi_reg)
                begin
                    cur_hi_next = p_hi;
                end
            end
            S_MRG_FLUSH:
            begin
                if (mcount_reg[MCNT_W-1])
                begin
                    run_ovf_next = 1'b1;
                end
                else
                begin
                    m_wr_en     = 1'b1;
                    mcount_next = mcount_reg + MCNT_W'(1);
                end
                pcount_next   = '0;
                ovf_seen_next = 1'b0;
                e_next        = '0;
            end
            S_EMIT_RD, S_LK_RD:
            begin
                m_rd_en = 1'b1;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_kind_next  = KIND_LIST;
                    rsp_low_next   = m_lo;
                    rsp_high_next  = m_hi;
                    rsp_slot_next  = e_reg[MIDX_W-1:0];
                    rsp_found_next = 1'b0;
                    rsp_ovf_next   = run_ovf_reg;
                    rsp_last_next  = e_at_end;
                    e_next         = e_inc;
                end
            end
            S_LK_CMP:
            begin
                if (lk_hit)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_kind_next  = KIND_LOOKUP;
                        rsp_low_next   = m_lo;
                        rsp_high_next  = m_hi;
                        rsp_slot_next  = e_reg[MIDX_W-1:0];
                        rsp_found_next = 1'b1;
                        rsp_ovf_next   = 1'b0;
                        rsp_last_next  = 1'b1;
                    end
                end
                else
                begin
                    e_next = e_inc;
                end
            end
            S_LK_MISS:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_kind_next  = KIND_LOOKUP;
                    rsp_low_next   = '0;
                    rsp_high_next  = '0;
                    rsp_slot_next  = '0;
                    rsp_found_next = 1'b0;
                    rsp_ovf_next   = 1'b0;
                    rsp_last_next  = 1'b1;
                end
            end
            default:
            begin
                p_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pcount_reg    <= '0;
            mcount_reg    <= '0;
            ovf_seen_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pcount_reg    <= pcount_next;
            mcount_reg    <= mcount_next;
            ovf_seen_reg  <= ovf_seen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        last_reg      <= last_next;
        q_reg         <= q_next;
        run_ovf_reg   <= run_ovf_next;
        j_reg         <= j_next;
        i_reg         <= i_next;
        e_reg         <= e_next;
        cur_lo_reg    <= cur_lo_next;
        cur_hi_reg    <= cur_hi_next;
        rsp_kind_reg  <= rsp_kind_next;
        rsp_low_reg   <= rsp_low_next;
        rsp_high_reg  <= rsp_high_next;
        rsp_slot_reg  <= rsp_slot_next;
        rsp_found_reg <= rsp_found_next;
        rsp_ovf_reg   <= rsp_ovf_next;
        rsp_last_reg  <= rsp_last_next;
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.kind     = rsp_kind_reg;
    assign rsp.out_low  = rsp_low_reg;
    assign rsp.out_high = rsp_high_reg;
    assign rsp.slot     = rsp_slot_reg;
    assign rsp.found    = rsp_found_reg;
    assign rsp.overflow = rsp_ovf_reg;
    assign rsp.last     = rsp_last_reg;

    `IMAL_ASSERT_IMPL(a_pcount_bound, clk, rst_n, 1'b1, pcount_reg <= PCNT_W'(MAX_RANGES), "pending count beyond capacity")
    `IMAL_ASSERT_IMPL(a_mcount_bound, clk, rst_n, 1'b1, mcount_reg <= MCNT_W'(MERGED_DEPTH), "merged count beyond depth")
    `IMAL_ASSERT_NEXT(a_last_add_busy, clk, rst_n, acc && (req.command == CMD_ADD) && req.last_range, !req.ready, "ready right after a last add")
    `IMAL_ASSERT_NEXT(a_flush_clears, clk, rst_n, state_reg == S_MRG_FLUSH, (pcount_reg == '0) && !ovf_seen_reg, "pending store not emptied after merge")
    `IMAL_ASSERT_IMPL(a_emit_in_list, clk, rst_n, state_reg == S_EMIT_OUT, e_reg < mcount_reg, "listing walks past merged count")
    `IMAL_ASSERT_IMPL(a_hit_ordered, clk, rst_n, rsp.valid && (rsp.kind == KIND_LOOKUP) && rsp.found, rsp.out_low <= rsp.out_high, "lookup hit on empty range")

endmodule

`default_nettype wire
